[src/square_tone_burst_envelope_macros.svh]
// Assertion macros shared by the tone burst generator modules.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SQUARE_TONE_BURST_ENVELOPE_MACROS_SVH
`define SQUARE_TONE_BURST_ENVELOPE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SQTB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SQTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sqtb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqtb_pkg: shared types and constants
// Register widths, reset values, register indexes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sqtb_pkg;

  // Field widths.
  localparam int HP_W     = 12;
  localparam int LEN_W    = 12;
  localparam int BURST_W  = 16;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = AMP_W + LEN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [HP_W-1:0]    HALF_PERIOD_RST = 12'd6;
  localparam logic [LEN_W-1:0]   ATTACK_LEN_RST  = 12'd96;
  localparam logic [LEN_W-1:0]   RELEASE_LEN_RST = 12'd192;
  localparam logic [BURST_W-1:0] BURST_LEN_RST   = 16'd1600;
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 15'd12000;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 3'd4;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PHASE,
    S_MUL,
    S_MAG_GO,
    S_MAG,
    S_FINISH
  } sqtb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // take the accepted beat, apply restart
    logic eval;         // set up default magnitude and sign
    logic div_start;    // launch the shared divider
    logic div_sel_mag;  // 0: frame / half period, 1: product / ramp length
    logic cap_phase;    // capture the sign from the quotient parity
    logic mul;          // register amplitude times ramp position
    logic cap_mag;      // capture the scaled magnitude
    logic finish;       // load the result and advance the frame counter
  } sqtb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic live;      // current frame belongs to a burst
    logic ramp;      // attack or release scaling applies
    logic div_done;  // divider quotient is ready
  } sqtb_status_t;

endpackage
`default_nettype wire

[src/sqtb_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqtb_ifs: stream channels of the tone burst generator
// The tick channel carries the restart flag in; the frame channel carries one
// stereo result out. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sqtb_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface sqtb_frame_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sqtb_pkg::SAMPLE_W-1:0]   left_sample;
  logic signed [sqtb_pkg::SAMPLE_W-1:0]   right_sample;
  logic                                   burst_active;
  logic                                   burst_last;

  modport source (output valid, output left_sample, output right_sample,
                  output burst_active, output burst_last, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input burst_active, input burst_last, output ready);
endinterface
`default_nettype wire

[src/sqtb_div.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "square_tone_burst_envelope_macros.svh"
// ----------------------------------------------------------------------------
// sqtb_div: serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle once the
// quotient is complete. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module sqtb_div #(
  parameter int DIV_W = 27
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [DIV_W-1:0]          dividend,
  input  wire logic [sqtb_pkg::HP_W-1:0] divisor,
  output logic      [DIV_W-1:0]          quotient,
  output logic                           done
);

  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int VW    = sqtb_pkg::HP_W;

  logic [CNT_W-1:0] count;
  logic             busy;
  logic [VW-1:0]    den;
  logic [VW-1:0]    rem;
  logic [VW:0]      shifted;
  logic [VW:0]      trial;
  logic             fits;

  // One restoring step: bring in the next dividend bit and try the subtract.
  assign shifted = {rem, quotient[DIV_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign fits    = (shifted >= {1'b0, den});

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      den      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

  // A new division is only launched while the unit is free.
  `SQTB_ASSERT_SAME(a_div_start_free, clk, rst, start, !busy, "divider restarted while busy")
  // The partial remainder always stays below the divisor.
  `SQTB_ASSERT_SAME(a_div_rem_bound, clk, rst, busy, rem < den, "remainder out of range")

endmodule
`default_nettype wire

[src/sqtb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqtb_dp: tone burst datapath
// Holds the configuration registers, frame counter and burst flag, the
// envelope multiplier, the shared divider and the result registers.
// ----------------------------------------------------------------------------
module sqtb_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [sqtb_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [sqtb_pkg::CFG_DATA_W-1:0]  wr_data,
  input  wire logic                             restart,
  input  wire sqtb_pkg::sqtb_cmd_t              cmd,
  output sqtb_pkg::sqtb_status_t                st,
  output logic signed [sqtb_pkg::SAMPLE_W-1:0]  left_sample,
  output logic signed [sqtb_pkg::SAMPLE_W-1:0]  right_sample,
  output logic                                  burst_active,
  output logic                                  burst_last
);

  localparam int BURST_W = sqtb_pkg::BURST_W;
  localparam int PROD_W  = sqtb_pkg::PROD_W;
  localparam int AMP_W   = sqtb_pkg::AMP_W;
  localparam int LEN_W   = sqtb_pkg::LEN_W;
  localparam int CMPW    = (COUNT_WIDTH > BURST_W) ? COUNT_WIDTH : BURST_W;
  localparam int DIV_W   = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;

  // Configuration registers.
  logic [sqtb_pkg::HP_W-1:0] half_period;
  logic [LEN_W-1:0]          attack_len;
  logic [LEN_W-1:0]          release_len;
  logic [BURST_W-1:0]        burst_len;
  logic [AMP_W-1:0]          amplitude;

  // Burst state and per-frame working registers.
  logic [COUNT_WIDTH-1:0] frame_index;
  logic                   active_flag;
  logic [AMP_W-1:0]       mag;
  logic                   neg;
  logic [PROD_W-1:0]      prod;

  // Derived frame values.
  logic [CMPW-1:0]           frame_ext;
  logic [CMPW-1:0]           burst_ext;
  logic [CMPW:0]             frame_p1;
  logic [BURST_W-1:0]        remain;
  logic                      ramp_att;
  logic                      ramp_rel;
  logic                      last;
  logic [LEN_W-1:0]          mul_x;
  logic [sqtb_pkg::HP_W-1:0] hp_eff;
  logic [DIV_W-1:0]          div_dividend;
  logic [LEN_W-1:0]          div_divisor;
  logic [DIV_W-1:0]          quotient;
  logic                      div_done;
  logic [sqtb_pkg::SAMPLE_W-1:0] mag_ext;
  logic [sqtb_pkg::SAMPLE_W-1:0] sample;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= sqtb_pkg::HALF_PERIOD_RST;
      attack_len  <= sqtb_pkg::ATTACK_LEN_RST;
      release_len <= sqtb_pkg::RELEASE_LEN_RST;
      burst_len   <= sqtb_pkg::BURST_LEN_RST;
      amplitude   <= sqtb_pkg::AMPLITUDE_RST;
    end else if (wr_en) begin
      case (wr_index)
        sqtb_pkg::CFG_HALF_PERIOD: half_period <= wr_data[sqtb_pkg::HP_W-1:0];
        sqtb_pkg::CFG_ATTACK_LEN:  attack_len  <= wr_data[LEN_W-1:0];
        sqtb_pkg::CFG_RELEASE_LEN: release_len <= wr_data[LEN_W-1:0];
        sqtb_pkg::CFG_BURST_LEN:   burst_len   <= wr_data[BURST_W-1:0];
        sqtb_pkg::CFG_AMPLITUDE:   amplitude   <= wr_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame classification. While live the frame is below burst_len, so it
  // fits in the burst length width and the remaining count is positive.
  assign frame_ext = CMPW'(frame_index);
  assign burst_ext = CMPW'(burst_len);
  assign frame_p1  = {1'b0, frame_ext} + (CMPW + 1)'(1);
  assign remain    = burst_len - frame_ext[BURST_W-1:0];
  assign ramp_att  = (attack_len != '0) && (frame_ext < CMPW'(attack_len));
  assign ramp_rel  = (release_len != '0) && (remain <= BURST_W'(release_len));
  assign last      = (frame_p1 >= {1'b0, burst_ext}) || (&frame_index);

  assign st.live     = active_flag && (frame_ext < burst_ext);
  assign st.ramp     = ramp_att || ramp_rel;
  assign st.div_done = div_done;

  // Operand selection for the multiplier and the shared divider.
  assign mul_x        = ramp_att ? frame_ext[LEN_W-1:0] : remain[LEN_W-1:0];
  assign hp_eff       = (half_period == '0) ? sqtb_pkg::HP_W'(1) : half_period;
  assign div_dividend = cmd.div_sel_mag ? DIV_W'(prod) : DIV_W'(frame_index);
  assign div_divisor  = cmd.div_sel_mag ? (ramp_att ? attack_len : release_len) : hp_eff;

  sqtb_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Magnitude, sign and envelope product.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      mag <= amplitude;
      neg <= 1'b0;
    end
    if (cmd.cap_phase) begin
      neg <= quotient[0];
    end
    if (cmd.mul) begin
      prod <= PROD_W'(amplitude) * PROD_W'(mul_x);
    end
    if (cmd.cap_mag) begin
      mag <= quotient[AMP_W-1:0];
    end
  end

  // Signed sample from sign and magnitude.
  assign mag_ext = {1'b0, mag};
  assign sample  = neg ? (sqtb_pkg::SAMPLE_W'(0) - mag_ext) : mag_ext;

  // Frame counter and burst flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index <= '0;
      active_flag <= 1'b0;
    end else if (cmd.load) begin
      if (restart) begin
        frame_index <= '0;
        active_flag <= 1'b1;
      end
    end else if (cmd.finish) begin
      if (st.live) begin
        frame_index <= frame_index + COUNT_WIDTH'(1);
        if (last) begin
          active_flag <= 1'b0;
        end
      end else begin
        active_flag <= 1'b0;
      end
    end
  end

  // Result registers, loaded once per frame.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      left_sample  <= st.live ? sample : '0;
      right_sample <= st.live ? sample : '0;
      burst_active <= st.live;
      burst_last   <= st.live && last;
    end
  end

endmodule
`default_nettype wire

[src/sqtb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "square_tone_burst_envelope_macros.svh"
// ----------------------------------------------------------------------------
// sqtb_ctrl: tone burst sequencer
// Steps one tick through classification, the phase division and the envelope
// multiply and division where they apply, and the result handoff to the output register.
// ----------------------------------------------------------------------------
module sqtb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire sqtb_pkg::sqtb_status_t st,
  output sqtb_pkg::sqtb_cmd_t         cmd
);

  sqtb_pkg::sqtb_state_t state;
  sqtb_pkg::sqtb_state_t state_next;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sqtb_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sqtb_pkg::S_IDLE: begin
        if (in_valid) state_next = sqtb_pkg::S_EVAL;
      end
      sqtb_pkg::S_EVAL: begin
        state_next = st.live ? sqtb_pkg::S_PHASE : sqtb_pkg::S_FINISH;
      end
      sqtb_pkg::S_PHASE: begin
        if (st.div_done) state_next = st.ramp ? sqtb_pkg::S_MUL : sqtb_pkg::S_FINISH;
      end
      sqtb_pkg::S_MUL: begin
        state_next = sqtb_pkg::S_MAG_GO;
      end
      sqtb_pkg::S_MAG_GO: begin
        state_next = sqtb_pkg::S_MAG;
      end
      sqtb_pkg::S_MAG: begin
        if (st.div_done) state_next = sqtb_pkg::S_FINISH;
      end
      sqtb_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = sqtb_pkg::S_IDLE;
      end
      default: begin
        state_next = sqtb_pkg::S_IDLE;
      end
    endcase
  end

  // Commands and input handshake.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      sqtb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sqtb_pkg::S_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.div_start = st.live;
      end
      sqtb_pkg::S_PHASE: begin
        cmd.cap_phase = st.div_done;
      end
      sqtb_pkg::S_MUL: begin
        cmd.mul = 1'b1;
      end
      sqtb_pkg::S_MAG_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_mag = 1'b1;
      end
      sqtb_pkg::S_MAG: begin
        cmd.div_sel_mag = 1'b1;
        cmd.cap_mag     = st.div_done;
      end
      sqtb_pkg::S_FINISH: begin
        cmd.finish = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // An accepted beat always moves on to classification.
  `SQTB_ASSERT_NEXT(a_accept_eval, clk, rst, in_valid && in_ready, state == sqtb_pkg::S_EVAL, "accepted beat not evaluated")
  // A finished frame waits while the previous result is still held.
  `SQTB_ASSERT_NEXT(a_finish_hold, clk, rst, state == sqtb_pkg::S_FINISH && out_valid && !out_ready, state == sqtb_pkg::S_FINISH && out_valid, "result overwritten before taken")

endmodule
`default_nettype wire

[src/square_tone_burst_envelope.sv]
// A tick beat runs through classification alone outside a burst, adds the phase division
// on the plateau and the envelope multiply and division in an attack or release frame; a held result adds its wait.
// A new tick is taken only once the previous frame has reached the output register; the serial divider
// (one quotient bit per cycle, 27 bits, used once or twice per frame) sets the pace.
// Reset (rst, synchronous, active high) restores the register defaults, clears
// the frame counter, leaves the generator idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_tone_burst_envelope: square-wave tone burst with linear envelope
// Produces one stereo frame per tick: a square tone of programmable period and
// amplitude, shaped by a linear attack and release over a programmable burst.
// ----------------------------------------------------------------------------
module square_tone_burst_envelope #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  sqtb_tick_if.sink                            tick,
  sqtb_frame_if.source                         stereo,
  input  wire logic                            wr_en,
  input  wire logic [sqtb_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [sqtb_pkg::CFG_DATA_W-1:0] wr_data
);

  sqtb_pkg::sqtb_cmd_t    cmd;
  sqtb_pkg::sqtb_status_t st;
  logic                   in_ready;
  logic                   out_valid;

  assign tick.ready   = in_ready;
  assign stereo.valid = out_valid;

  // Sequencer.
  sqtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (stereo.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Datapath with registers, envelope arithmetic and result registers.
  sqtb_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .restart      (tick.restart),
    .cmd          (cmd),
    .st           (st),
    .left_sample  (stereo.left_sample),
    .right_sample (stereo.right_sample),
    .burst_active (stereo.burst_active),
    .burst_last   (stereo.burst_last)
  );

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the square-wave tone burst generator
// Sends restart/tick beats and compares every stereo frame against a
// cycle-free model of the tone and envelope kept inside the bench. It covers
// register extremes, the special cases of the burst control, and a long
// random run of short bursts with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int RANDOM_TICKS = 675;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [sqtb_pkg::SAMPLE_W-1:0] left;
    logic [sqtb_pkg::SAMPLE_W-1:0] right;
    logic                          active;
    logic                          last;
  } stereo_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                            wr_en;
  logic [sqtb_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [sqtb_pkg::CFG_DATA_W-1:0] wr_data;

  sqtb_tick_if  tick_ch ();
  sqtb_frame_if frame_ch ();

  square_tone_burst_envelope #(.COUNT_WIDTH(COUNT_W)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .stereo   (frame_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #6 clk = ~clk;

  // Register copies and burst state of the bench model.
  logic [sqtb_pkg::HP_W-1:0]    hp_reg;
  logic [sqtb_pkg::LEN_W-1:0]   attack_reg;
  logic [sqtb_pkg::LEN_W-1:0]   release_reg;
  logic [sqtb_pkg::BURST_W-1:0] burst_reg;
  logic [sqtb_pkg::AMP_W-1:0]   amp_reg;
  logic [COUNT_W-1:0]           frame_count;
  logic                         burst_on;

  stereo_frame_t pending_frames[$];
  int error_count = 0;
  int ticks_sent = 0;
  int frames_checked = 0;
  int bursts_done = 0;
  int settings_used = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  // Gap length for either side: mostly none or short, a few long.
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Expected frame for one tick beat; advances the burst state.
  function automatic stereo_frame_t tone_frame(input logic restart);
    stereo_frame_t f;
    logic [31:0] fr;
    logic [31:0] hp;
    logic [31:0] mag;
    logic [31:0] span;
    logic        last;
    f = '0;
    if (restart) begin
      frame_count = '0;
      burst_on = 1'b1;
    end
    fr = 32'(frame_count);
    if (!burst_on || fr >= 32'(burst_reg)) begin
      burst_on = 1'b0;
      return f;
    end
    last = (fr + 1 >= 32'(burst_reg)) || (frame_count == COUNT_MAX);
    hp = (hp_reg == '0) ? 32'd1 : 32'(hp_reg);
    mag = 32'(amp_reg);
    span = 32'(burst_reg) - fr;
    // Attack ramp wins over release when both would apply.
    if (attack_reg != '0 && fr < 32'(attack_reg)) begin
      mag = (mag * fr) / 32'(attack_reg);
    end else if (release_reg != '0 && span <= 32'(release_reg)) begin
      mag = (mag * span) / 32'(release_reg);
    end
    f.left = ((fr / hp) & 32'd1) != 0 ? sqtb_pkg::SAMPLE_W'(32'd0 - mag)
                                      : sqtb_pkg::SAMPLE_W'(mag);
    f.right = f.left;
    f.active = 1'b1;
    f.last = last;
    frame_count = frame_count + 1'b1;
    if (last) burst_on = 1'b0;
    return f;
  endfunction

  function automatic void check_field(input string name,
                                      input logic [sqtb_pkg::SAMPLE_W-1:0] want,
                                      input logic [sqtb_pkg::SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(want), $signed(got));
      error_count++;
    end
  endfunction

  // Result beats are checked in order against the oldest expectation.
  always @(posedge clk) begin
    stereo_frame_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t ns: frame beat with no tick waiting, left %0d", $time,
                 $signed(frame_ch.left_sample));
        error_count++;
      end else begin
        want = pending_frames.pop_front();
        check_field("left_sample", want.left, frame_ch.left_sample);
        check_field("right_sample", want.right, frame_ch.right_sample);
        check_field("burst_active", sqtb_pkg::SAMPLE_W'(want.active),
                    sqtb_pkg::SAMPLE_W'(frame_ch.burst_active));
        check_field("burst_last", sqtb_pkg::SAMPLE_W'(want.last),
                    sqtb_pkg::SAMPLE_W'(frame_ch.burst_last));
        frames_checked++;
        if (want.last) bursts_done++;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      frame_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      frame_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
    end
  end

  // Sends one tick beat; entered and left at a falling edge.
  task automatic send_tick(input logic restart);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.restart <= restart;
    do @(posedge clk); while (!tick_ch.ready);
    pending_frames.push_back(tone_frame(restart));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected frame has arrived.
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_frames.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sqtb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sqtb_pkg::CFG_DATA_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      sqtb_pkg::CFG_HALF_PERIOD: hp_reg = data[sqtb_pkg::HP_W-1:0];
      sqtb_pkg::CFG_ATTACK_LEN:  attack_reg = data[sqtb_pkg::LEN_W-1:0];
      sqtb_pkg::CFG_RELEASE_LEN: release_reg = data[sqtb_pkg::LEN_W-1:0];
      sqtb_pkg::CFG_BURST_LEN:   burst_reg = data[sqtb_pkg::BURST_W-1:0];
      sqtb_pkg::CFG_AMPLITUDE:   amp_reg = data[sqtb_pkg::AMP_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all five registers; unused upper data bits carry random values.
  task automatic program_all(input logic [sqtb_pkg::HP_W-1:0] hp,
                             input logic [sqtb_pkg::LEN_W-1:0] atk,
                             input logic [sqtb_pkg::LEN_W-1:0] rel,
                             input logic [sqtb_pkg::BURST_W-1:0] blen,
                             input logic [sqtb_pkg::AMP_W-1:0] amp);
    write_reg(sqtb_pkg::CFG_HALF_PERIOD, {4'($urandom_range(0, 15)), hp});
    write_reg(sqtb_pkg::CFG_ATTACK_LEN, {4'($urandom_range(0, 15)), atk});
    write_reg(sqtb_pkg::CFG_RELEASE_LEN, {4'($urandom_range(0, 15)), rel});
    write_reg(sqtb_pkg::CFG_BURST_LEN, blen);
    write_reg(sqtb_pkg::CFG_AMPLITUDE, {1'($urandom_range(0, 1)), amp});
    settings_used++;
  endtask

  // Reset defaults: idle ticks give silence, then a burst starts in its attack.
  task automatic test_idle_and_restart();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_drained();
  endtask

  // Register extremes: zero half period, no ramps, full amplitude, long ramps
  // over a tiny burst, and a release longer than the whole burst.
  task automatic test_register_extremes();
    program_all('0, '0, '0, 16'd3, 15'd32767);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_drained();
    program_all(12'd4095, 12'd4095, 12'd4095, 16'd2, 15'd32767);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
    program_all(12'd1, '0, 12'd4095, 16'd5, 15'd32767);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    wait_drained();
  endtask

  // A zero burst length starts nothing; a burst length lowered below the
  // running frame ends the burst at once.
  task automatic test_burst_cut();
    program_all(12'd1, 12'd2, 12'd3, '0, 15'd20000);
    send_tick(1'b1);
    wait_drained();
    write_reg(sqtb_pkg::CFG_BURST_LEN, 16'd100);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    wait_drained();
    write_reg(sqtb_pkg::CFG_BURST_LEN, 16'd3);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();
  endtask

  // Random settings, mostly short bursts run to the end, with the odd early
  // restart and bursts carried across a change of settings.
  task automatic test_random_bursts();
    logic [sqtb_pkg::HP_W-1:0]    hp;
    logic [sqtb_pkg::LEN_W-1:0]   atk;
    logic [sqtb_pkg::LEN_W-1:0]   rel;
    logic [sqtb_pkg::BURST_W-1:0] blen;
    logic [sqtb_pkg::AMP_W-1:0]   amp;
    int start;
    int count;
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_TICKS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: hp = '0;
        1: hp = 12'd1;
        2: hp = 12'd4095;
        3: hp = sqtb_pkg::HP_W'($urandom_range(1, 4095));
        default: hp = sqtb_pkg::HP_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0: atk = '0;
        1: atk = 12'd4095;
        2: atk = sqtb_pkg::LEN_W'($urandom_range(1, 4095));
        default: atk = sqtb_pkg::LEN_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0: rel = '0;
        1: rel = 12'd4095;
        2: rel = sqtb_pkg::LEN_W'($urandom_range(1, 4095));
        default: rel = sqtb_pkg::LEN_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 19))
        0: blen = '0;
        1: blen = 16'd65535;
        2: blen = 16'd1;
        3: blen = sqtb_pkg::BURST_W'($urandom_range(1, 65535));
        default: blen = sqtb_pkg::BURST_W'($urandom_range(1, 48));
      endcase
      case ($urandom_range(0, 9))
        0: amp = '0;
        1: amp = 15'd32767;
        default: amp = sqtb_pkg::AMP_W'($urandom_range(0, 32767));
      endcase
      program_all(hp, atk, rel, blen, amp);
      // Writes to the spare indexes must leave every register alone.
      if ($urandom_range(0, 3) == 0) begin
        for (int i = sqtb_pkg::CFG_AMPLITUDE + 1; i < (1 << sqtb_pkg::CFG_IDX_W); i++) begin
          write_reg(sqtb_pkg::CFG_IDX_W'(i), sqtb_pkg::CFG_DATA_W'($urandom));
        end
      end
      steady = ($urandom_range(0, 3) == 0);
      count = $urandom_range(15, 50);
      repeat (count) begin
        if (!burst_on) send_tick($urandom_range(0, 9) != 0);
        else send_tick($urandom_range(0, 29) == 0);
      end
      steady = 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.restart = 1'b0;
    frame_ch.ready = 1'b0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    hp_reg = sqtb_pkg::HALF_PERIOD_RST;
    attack_reg = sqtb_pkg::ATTACK_LEN_RST;
    release_reg = sqtb_pkg::RELEASE_LEN_RST;
    burst_reg = sqtb_pkg::BURST_LEN_RST;
    amp_reg = sqtb_pkg::AMPLITUDE_RST;
    frame_count = '0;
    burst_on = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_and_restart();
    test_register_extremes();
    test_burst_cut();
    test_random_bursts();

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Summary: %0d tick beats under %0d register settings.", ticks_sent,
             settings_used + 1);
    $display("Summary: %0d frames checked, %0d bursts ran to their last frame.",
             frames_checked, bursts_done);
    if (error_count == 0 && pending_frames.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #12_000_000;
    $display("Timeout with %0d frames still expected.", pending_frames.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
